FILE: hdl/mjp_pkg.sv
package mjp_pkg;

	// Output coordinate width. A join point is clamped to this signed range.
	localparam int COORD_BITS = 32;
	// Unit vectors and the cross product are signed Q2.30.
	localparam int UNIT_SHIFT = 30;
	localparam int HW_BITS = 31;
	localparam logic [HW_BITS-1:0] HW_RESET = 31'd65536;
	// Smallest cross product magnitude, in Q2.30, that is not treated as parallel.
	localparam logic [31:0] SIN_MIN = 32'd10737419;

	localparam int SQRT_STEPS = 32;
	localparam int UDIV_STEPS = 31;
	localparam int ODIV_STEPS = 40;

	// Unit vector path: difference, magnitude, shift search, shift, squares, sum,
	// root steps, dividend setup, divide steps, sign.
	localparam int UNIT_LAT = 6 + SQRT_STEPS + 1 + UDIV_STEPS + 1;
	// Offset divider: dividend setup, divide steps, sign.
	localparam int OFF_LAT = ODIV_STEPS + 2;
	localparam int CROSS_END = UNIT_LAT + 3;
	localparam int OFF_END = CROSS_END + OFF_LAT;
	localparam int PIPE_LAT = OFF_END + 2;

	typedef struct packed {
		logic               zero;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} unit_vec_t;

	typedef struct packed {
		logic               inner;
		logic signed [31:0] jx;
		logic signed [31:0] jy;
	} side_t;

endpackage

FILE: hdl/mjp_unit.sv
module mjp_unit (
	input  logic                clk,
	input  logic                ce,
	input  logic signed [31:0]  end_x,
	input  logic signed [31:0]  end_y,
	input  logic signed [31:0]  joint_x,
	input  logic signed [31:0]  joint_y,
	output mjp_pkg::unit_vec_t  uv
);

	localparam int SQ = mjp_pkg::SQRT_STEPS;
	localparam int DV = mjp_pkg::UDIV_STEPS;

	logic signed [32:0] dx_s1, dy_s1;
	logic [32:0] ax_s2, ay_s2;
	logic xneg_s2, yneg_s2;
	logic [32:0] ax_s3, ay_s3;
	logic [1:0]  rsh_s3;
	logic [4:0]  lsh_s3;
	logic zero_s3, xneg_s3, yneg_s3;
	logic [30:0] nx_s4, ny_s4;
	logic zero_s4, xneg_s4, yneg_s4;
	logic [61:0] sqx_s5, sqy_s5;
	logic [30:0] nx_s5, ny_s5;
	logic zero_s5, xneg_s5, yneg_s5;

	logic [32:0] m;
	logic [4:0]  pos;
	logic [32:0] shx, shy;

	// Square root pipeline, one result bit per stage.
	logic [63:0] sq_rad  [0:SQ];
	logic [33:0] sq_rem  [0:SQ];
	logic [31:0] sq_root [0:SQ];
	logic [30:0] sq_nx   [0:SQ];
	logic [30:0] sq_ny   [0:SQ];
	logic        sq_zero [0:SQ];
	logic        sq_xneg [0:SQ];
	logic        sq_yneg [0:SQ];
	logic [35:0] sq_r    [0:SQ-1];
	logic [35:0] sq_t    [0:SQ-1];
	logic        sq_ge   [0:SQ-1];

	// Two dividers side by side, one quotient bit per stage.
	logic [31:0] dv_remx [0:DV];
	logic [31:0] dv_remy [0:DV];
	logic [30:0] dv_lox  [0:DV];
	logic [30:0] dv_loy  [0:DV];
	logic [30:0] dv_qx   [0:DV];
	logic [30:0] dv_qy   [0:DV];
	logic [31:0] dv_den  [0:DV];
	logic        dv_zero [0:DV];
	logic        dv_xneg [0:DV];
	logic        dv_yneg [0:DV];
	logic [32:0] dv_rx   [0:DV-1];
	logic [32:0] dv_ry   [0:DV-1];
	logic        dv_gex  [0:DV-1];
	logic        dv_gey  [0:DV-1];

	logic [61:0] nnx, nny;

	always_comb begin
		m = (ax_s2 > ay_s2) ? ax_s2 : ay_s2;
		pos = '0;
		for (int i = 0; i < 31; i++) begin
			if (m[i]) begin
				pos = 5'(i);
			end
		end
		shx = ax_s3 >> rsh_s3;
		shy = ay_s3 >> rsh_s3;
		for (int k = 0; k < SQ; k++) begin
			sq_r[k] = {sq_rem[k], sq_rad[k][63:62]};
			sq_t[k] = {2'b00, sq_root[k], 2'b01};
			sq_ge[k] = sq_r[k] >= sq_t[k];
		end
		nnx = {1'b0, sq_nx[SQ], 30'd0} + {31'd0, sq_root[SQ][31:1]};
		nny = {1'b0, sq_ny[SQ], 30'd0} + {31'd0, sq_root[SQ][31:1]};
		for (int k = 0; k < DV; k++) begin
			dv_rx[k] = {dv_remx[k], dv_lox[k][30]};
			dv_ry[k] = {dv_remy[k], dv_loy[k][30]};
			dv_gex[k] = dv_rx[k] >= {1'b0, dv_den[k]};
			dv_gey[k] = dv_ry[k] >= {1'b0, dv_den[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			dx_s1 <= {joint_x[31], joint_x} - {end_x[31], end_x};
			dy_s1 <= {joint_y[31], joint_y} - {end_y[31], end_y};

			ax_s2 <= dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
			ay_s2 <= dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
			xneg_s2 <= dx_s1[32];
			yneg_s2 <= dy_s1[32];

			// Bring the larger magnitude into [2^30, 2^31).
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			rsh_s3 <= m[32] ? 2'd2 : (m[31] ? 2'd1 : 2'd0);
			lsh_s3 <= (m[32:31] == 2'b00) ? 5'd30 - pos : 5'd0;
			zero_s3 <= (m == '0);
			xneg_s3 <= xneg_s2;
			yneg_s3 <= yneg_s2;

			nx_s4 <= shx[30:0] << lsh_s3;
			ny_s4 <= shy[30:0] << lsh_s3;
			zero_s4 <= zero_s3;
			xneg_s4 <= xneg_s3;
			yneg_s4 <= yneg_s3;

			sqx_s5 <= nx_s4 * nx_s4;
			sqy_s5 <= ny_s4 * ny_s4;
			nx_s5 <= nx_s4;
			ny_s5 <= ny_s4;
			zero_s5 <= zero_s4;
			xneg_s5 <= xneg_s4;
			yneg_s5 <= yneg_s4;

			sq_rad[0] <= {1'b0, 63'(sqx_s5) + 63'(sqy_s5)};
			sq_rem[0] <= '0;
			sq_root[0] <= '0;
			sq_nx[0] <= nx_s5;
			sq_ny[0] <= ny_s5;
			sq_zero[0] <= zero_s5;
			sq_xneg[0] <= xneg_s5;
			sq_yneg[0] <= yneg_s5;
			for (int k = 0; k < SQ; k++) begin
				sq_rad[k+1] <= {sq_rad[k][61:0], 2'b00};
				sq_rem[k+1] <= sq_ge[k] ? 34'(sq_r[k] - sq_t[k]) : sq_r[k][33:0];
				sq_root[k+1] <= {sq_root[k][30:0], sq_ge[k]};
				sq_nx[k+1] <= sq_nx[k];
				sq_ny[k+1] <= sq_ny[k];
				sq_zero[k+1] <= sq_zero[k];
				sq_xneg[k+1] <= sq_xneg[k];
				sq_yneg[k+1] <= sq_yneg[k];
			end

			// Rounded quotient: (n * 2^30 + len/2) / len, at most 2^30.
			dv_remx[0] <= {1'b0, nnx[61:31]};
			dv_remy[0] <= {1'b0, nny[61:31]};
			dv_lox[0] <= nnx[30:0];
			dv_loy[0] <= nny[30:0];
			dv_qx[0] <= '0;
			dv_qy[0] <= '0;
			dv_den[0] <= sq_root[SQ];
			dv_zero[0] <= sq_zero[SQ];
			dv_xneg[0] <= sq_xneg[SQ];
			dv_yneg[0] <= sq_yneg[SQ];
			for (int k = 0; k < DV; k++) begin
				dv_remx[k+1] <= dv_gex[k] ? 32'(dv_rx[k] - {1'b0, dv_den[k]}) : dv_rx[k][31:0];
				dv_remy[k+1] <= dv_gey[k] ? 32'(dv_ry[k] - {1'b0, dv_den[k]}) : dv_ry[k][31:0];
				dv_lox[k+1] <= {dv_lox[k][29:0], 1'b0};
				dv_loy[k+1] <= {dv_loy[k][29:0], 1'b0};
				dv_qx[k+1] <= {dv_qx[k][29:0], dv_gex[k]};
				dv_qy[k+1] <= {dv_qy[k][29:0], dv_gey[k]};
				dv_den[k+1] <= dv_den[k];
				dv_zero[k+1] <= dv_zero[k];
				dv_xneg[k+1] <= dv_xneg[k];
				dv_yneg[k+1] <= dv_yneg[k];
			end

			uv.zero <= dv_zero[DV];
			uv.x <= dv_xneg[DV] ? -$signed({1'b0, dv_qx[DV]}) : $signed({1'b0, dv_qx[DV]});
			uv.y <= dv_yneg[DV] ? -$signed({1'b0, dv_qy[DV]}) : $signed({1'b0, dv_qy[DV]});
		end
	end

endmodule

FILE: hdl/mjp_offset.sv
module mjp_offset (
	input  logic               clk,
	input  logic               ce,
	input  logic [61:0]        num_mag,
	input  logic [31:0]        den,
	input  logic               neg,
	output logic signed [40:0] off
);

	localparam int DV = mjp_pkg::ODIV_STEPS;

	logic [31:0] rem [0:DV];
	logic [39:0] lo  [0:DV];
	logic [39:0] q   [0:DV];
	logic [31:0] dn  [0:DV];
	logic        ng  [0:DV];
	logic [32:0] r   [0:DV-1];
	logic        ge  [0:DV-1];
	logic [62:0] nn;

	always_comb begin
		// Round to nearest by adding half the divisor before dividing.
		nn = {1'b0, num_mag} + {32'd0, den[31:1]};
		for (int k = 0; k < DV; k++) begin
			r[k] = {rem[k], lo[k][39]};
			ge[k] = r[k] >= {1'b0, dn[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem[0] <= {9'd0, nn[62:40]};
			lo[0] <= nn[39:0];
			q[0] <= '0;
			dn[0] <= den;
			ng[0] <= neg;
			for (int k = 0; k < DV; k++) begin
				rem[k+1] <= ge[k] ? 32'(r[k] - {1'b0, dn[k]}) : r[k][31:0];
				lo[k+1] <= {lo[k][38:0], 1'b0};
				q[k+1] <= {q[k][38:0], ge[k]};
				dn[k+1] <= dn[k];
				ng[k+1] <= ng[k];
			end
			off <= ng[DV] ? -$signed({1'b0, q[DV]}) : $signed({1'b0, q[DV]});
		end
	end

endmodule

FILE: hdl/miter_join_point.sv
// Channel   Direction  Beat contents
// s_axis    in         tdata: from_x, from_y, joint_x, joint_y, to_x, to_y; tuser: mode
// m_axis    out        tdata: point_x, point_y; tuser: degenerate, saturated
// cfg       in         half_width, written whenever cfg_we is high
//
// One join point leaves for every beat taken, in order, one beat per cycle sustained
// while output beats are taken. The latency is set by the two pipelined square roots
// and unit-vector dividers (one bit per stage) and by the 40-stage offset divider.
// arst_n clears the valid bits and loads half_width with 1.0; no clearing pass is needed.
// When the output beat is not taken, the whole pipeline holds and s_axis_tready drops,
// so no beat is lost or repeated; a bubble in the output frees the pipeline again.
module miter_join_point (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// from_x, from_y, joint_x, joint_y, to_x, to_y, 32 bits each from bit 0 up
	input  logic [191:0]                 s_axis_tdata,
	// mode
	input  logic [0:0]                   s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// point_x, point_y, 32 bits each from bit 0 up
	output logic [63:0]                  m_axis_tdata,
	// degenerate, saturated
	output logic [1:0]                   m_axis_tuser,
	input  logic                         cfg_we,
	input  logic [mjp_pkg::HW_BITS-1:0]  cfg_wdata
);

	localparam int PL = mjp_pkg::PIPE_LAT;
	localparam int CE = mjp_pkg::CROSS_END;
	localparam int OE = mjp_pkg::OFF_END;
	localparam int CB = mjp_pkg::COORD_BITS;

	logic ce;
	logic [mjp_pkg::HW_BITS-1:0] hw_q;

	logic signed [31:0] from_x, from_y, joint_x, joint_y, to_x, to_y;
	mjp_pkg::unit_vec_t uv1, uv2;

	// Valid bits and joint/mode travel alongside the arithmetic.
	logic            vld_s  [1:PL];
	mjp_pkg::side_t  side_s [1:PL];
	logic            deg_s  [CE:PL];

	// Join section: cross product, offset numerators, divisor.
	logic signed [63:0] cp1_j1, cp2_j1;
	logic signed [32:0] sx_j1, sy_j1;
	logic               zero_j1;
	logic signed [63:0] s60_j2, numx_j2, numy_j2;
	logic               zero_j2;
	logic [61:0]        magx_j3, magy_j3;
	logic [31:0]        den_j3;
	logic               negx_j3, negy_j3;

	logic [63:0] s60_mag, numx_mag, numy_mag;
	logic [31:0] s30m;

	logic signed [40:0] offx, offy;
	logic signed [41:0] px_e1, py_e1;
	logic signed [31:0] pt_x_e2, pt_y_e2;
	logic               sat_e2;
	logic               satx, saty;

	assign ce = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	assign from_x  = s_axis_tdata[31:0];
	assign from_y  = s_axis_tdata[63:32];
	assign joint_x = s_axis_tdata[95:64];
	assign joint_y = s_axis_tdata[127:96];
	assign to_x    = s_axis_tdata[159:128];
	assign to_y    = s_axis_tdata[191:160];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= mjp_pkg::HW_RESET;
		end else if (cfg_we) begin
			hw_q <= cfg_wdata;
		end
	end

	// d1 from the first segment, d2 from the second; both point into the joint.
	mjp_unit u_d1 (
		.clk     (clk),
		.ce      (ce),
		.end_x   (from_x),
		.end_y   (from_y),
		.joint_x (joint_x),
		.joint_y (joint_y),
		.uv      (uv1)
	);

	mjp_unit u_d2 (
		.clk     (clk),
		.ce      (ce),
		.end_x   (to_x),
		.end_y   (to_y),
		.joint_x (joint_x),
		.joint_y (joint_y),
		.uv      (uv2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PL; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (ce) begin
			vld_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= PL; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_comb begin
		s60_mag = s60_j2[63] ? 64'(-s60_j2) : 64'(s60_j2);
		numx_mag = numx_j2[63] ? 64'(-numx_j2) : 64'(numx_j2);
		numy_mag = numy_j2[63] ? 64'(-numy_j2) : 64'(numy_j2);
		// Round the Q4.60 cross product to Q2.30.
		s30m = 32'((s60_mag + (64'd1 << (mjp_pkg::UNIT_SHIFT - 1))) >> mjp_pkg::UNIT_SHIFT);
		// A coordinate saturates when the bits from the sign position up disagree.
		satx = !((px_e1[41:CB-1] == '0) || (px_e1[41:CB-1] == '1));
		saty = !((py_e1[41:CB-1] == '0) || (py_e1[41:CB-1] == '1));
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s[1] <= '{inner: s_axis_tuser[0], jx: joint_x, jy: joint_y};
			for (int k = 2; k <= PL; k++) begin
				side_s[k] <= side_s[k-1];
			end

			cp1_j1 <= uv2.y * uv1.x;
			cp2_j1 <= uv2.x * uv1.y;
			sx_j1 <= {uv1.x[31], uv1.x} + {uv2.x[31], uv2.x};
			sy_j1 <= {uv1.y[31], uv1.y} + {uv2.y[31], uv2.y};
			zero_j1 <= uv1.zero || uv2.zero;

			s60_j2 <= cp1_j1 - cp2_j1;
			numx_j2 <= sx_j1 * $signed({1'b0, hw_q});
			numy_j2 <= sy_j1 * $signed({1'b0, hw_q});
			zero_j2 <= zero_j1;

			magx_j3 <= numx_mag[61:0];
			magy_j3 <= numy_mag[61:0];
			den_j3 <= s30m;
			negx_j3 <= numx_j2[63] ^ s60_j2[63];
			negy_j3 <= numy_j2[63] ^ s60_j2[63];
			deg_s[CE] <= zero_j2 || (s30m < mjp_pkg::SIN_MIN);
			for (int k = CE + 1; k <= PL; k++) begin
				deg_s[k] <= deg_s[k-1];
			end

			// Outer side moves against the offset, inner side along it.
			if (side_s[OE].inner) begin
				px_e1 <= {{10{side_s[OE].jx[31]}}, side_s[OE].jx} + {offx[40], offx};
				py_e1 <= {{10{side_s[OE].jy[31]}}, side_s[OE].jy} + {offy[40], offy};
			end else begin
				px_e1 <= {{10{side_s[OE].jx[31]}}, side_s[OE].jx} - {offx[40], offx};
				py_e1 <= {{10{side_s[OE].jy[31]}}, side_s[OE].jy} - {offy[40], offy};
			end

			if (deg_s[PL-1]) begin
				pt_x_e2 <= '0;
				pt_y_e2 <= '0;
				sat_e2 <= 1'b0;
			end else begin
				pt_x_e2 <= satx ? {px_e1[41], {(CB-1){!px_e1[41]}}} : px_e1[CB-1:0];
				pt_y_e2 <= saty ? {py_e1[41], {(CB-1){!py_e1[41]}}} : py_e1[CB-1:0];
				sat_e2 <= satx || saty;
			end
		end
	end

	mjp_offset u_offx (
		.clk     (clk),
		.ce      (ce),
		.num_mag (magx_j3),
		.den     (den_j3),
		.neg     (negx_j3),
		.off     (offx)
	);

	mjp_offset u_offy (
		.clk     (clk),
		.ce      (ce),
		.num_mag (magy_j3),
		.den     (den_j3),
		.neg     (negy_j3),
		.off     (offy)
	);

	assign m_axis_tvalid = vld_s[PL];
	assign m_axis_tdata = {pt_y_e2, pt_x_e2};
	assign m_axis_tuser = {sat_e2, deg_s[PL]};

`ifndef NO_ASSERTIONS
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
		else $error("degenerate join with nonzero point or saturation");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tdata[31:0] == 32'h7fffffff || m_axis_tdata[31:0] == 32'h80000000 ||
			m_axis_tdata[63:32] == 32'h7fffffff || m_axis_tdata[63:32] == 32'h80000000)
		else $error("saturation flagged without a clamped coordinate");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input held off without a waiting output beat");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s[1])
		else $error("accepted beat did not enter the pipeline");
`endif

endmodule

FILE: dv/miter_join_point_tb.sv
module miter_join_point_tb;
	// Self-checking testbench for the miter join block. Every beat that the block
	// accepts is run through a predictor written here, and the expected join
	// point is queued. Each beat that leaves the block is checked against the
	// oldest queued point, field by field.

	timeunit 1ns;
	timeprecision 1ps;

	// One input beat, unpacked into its fields.
	typedef struct {
		logic signed [31:0] fx, fy, jx, jy, tx, ty;
		logic               inner;
	} joint_in_t;

	// One expected output beat.
	typedef struct {
		logic [31:0] px, py;
		logic        degen, sat;
	} join_pt_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_we;
	logic [mjp_pkg::HW_BITS-1:0] cfg_wdata;

	// The half-width that the predictor uses; it follows every register write.
	logic [mjp_pkg::HW_BITS-1:0] hw_shadow;
	join_pt_t           join_q[$];
	int unsigned        err_count;
	int unsigned        beats_in;
	// Receiver controls: the number of long holds asked for so far, and the end
	// phase with no idling.
	int unsigned        hold_req;
	bit                 no_idle;

	miter_join_point u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned abs64(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Floor square root, one result bit per pass.
	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Q2.30 unit vector of (dx, dy). Returns 0 when the vector has zero length.
	// The larger magnitude is normalized into [2^30, 2^31) before the root.
	function automatic bit unit_dir(longint dx, longint dy, output longint ux,
			output longint uy);
		longint unsigned ax, ay, m, len, qx, qy;
		ax = abs64(dx);
		ay = abs64(dy);
		m = (ax > ay) ? ax : ay;
		ux = 0;
		uy = 0;
		if (m == 0)
			return 0;
		while (m >= (64'd1 << 31)) begin
			ax >>= 1;
			ay >>= 1;
			m >>= 1;
		end
		while (m < (64'd1 << 30)) begin
			ax <<= 1;
			ay <<= 1;
			m <<= 1;
		end
		len = floor_sqrt(ax * ax + ay * ay);
		qx = ((ax << mjp_pkg::UNIT_SHIFT) + len / 2) / len;
		qy = ((ay << mjp_pkg::UNIT_SHIFT) + len / 2) / len;
		ux = (dx < 0) ? -longint'(qx) : longint'(qx);
		uy = (dy < 0) ? -longint'(qy) : longint'(qy);
		return 1;
	endfunction

	// Rounded (sum * half_width) / s, ties away from zero.
	function automatic longint miter_offset(longint sum, longint s30);
		longint          num;
		longint unsigned den, q;
		num = sum * longint'({33'd0, hw_shadow});
		den = abs64(s30);
		q = (abs64(num) + den / 2) / den;
		return ((num < 0) != (s30 < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] clamp_coord(longint v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic join_pt_t predict_join(joint_in_t b);
		join_pt_t        r;
		longint          jx, jy, d1x, d1y, d2x, d2y, s60, s30, ox, oy;
		longint unsigned s30m;
		logic            sat;
		r = '{px: '0, py: '0, degen: 1'b1, sat: 1'b0};
		jx = b.jx;
		jy = b.jy;
		if (!unit_dir(jx - longint'(b.fx), jy - longint'(b.fy), d1x, d1y))
			return r;
		if (!unit_dir(jx - longint'(b.tx), jy - longint'(b.ty), d2x, d2y))
			return r;
		s60 = d2y * d1x - d2x * d1y;
		s30m = (abs64(s60) + (64'd1 << (mjp_pkg::UNIT_SHIFT - 1))) >> mjp_pkg::UNIT_SHIFT;
		// Nearly parallel segments have no usable miter.
		if (s30m < longint'(mjp_pkg::SIN_MIN))
			return r;
		s30 = (s60 < 0) ? -longint'(s30m) : longint'(s30m);
		ox = miter_offset(d1x + d2x, s30);
		oy = miter_offset(d1y + d2y, s30);
		sat = 1'b0;
		r.px = clamp_coord(b.inner ? jx + ox : jx - ox, sat);
		r.py = clamp_coord(b.inner ? jy + oy : jy - oy, sat);
		r.degen = 1'b0;
		r.sat = sat;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_count++;
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
	endtask

	// Input monitor: every accepted beat gets its prediction queued. Inputs
	// only change at the falling edge, so these values are stable here.
	always @(posedge clk) begin
		joint_in_t b;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			b.fx = s_axis_tdata[31:0];
			b.fy = s_axis_tdata[63:32];
			b.jx = s_axis_tdata[95:64];
			b.jy = s_axis_tdata[127:96];
			b.tx = s_axis_tdata[159:128];
			b.ty = s_axis_tdata[191:160];
			b.inner = s_axis_tuser[0];
			join_q.push_back(predict_join(b));
			beats_in++;
		end
	end

	// Output checker: each accepted result beat is compared with the oldest
	// expectation.
	always @(posedge clk) begin
		join_pt_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (join_q.size() == 0) begin
				report_mismatch("result beat with nothing expected", m_axis_tdata[31:0],
					32'd0);
			end else begin
				w = join_q.pop_front();
				if (m_axis_tdata[31:0] !== w.px)
					report_mismatch("point_x", m_axis_tdata[31:0], w.px);
				if (m_axis_tdata[63:32] !== w.py)
					report_mismatch("point_y", m_axis_tdata[63:32], w.py);
				if (m_axis_tuser[0] !== w.degen)
					report_mismatch("degenerate", {31'd0, m_axis_tuser[0]}, {31'd0, w.degen});
				if (m_axis_tuser[1] !== w.sat)
					report_mismatch("saturated", {31'd0, m_axis_tuser[1]}, {31'd0, w.sat});
			end
		end
	end

	// Receiver: random ready and stalled runs, a long hold when a test asks for
	// one, and a steady ready in the last phase.
	always @(negedge clk) begin
		static int unsigned run_left = 0;
		static bit          run_ready = 1'b1;
		static int unsigned hold_seen = 0;
		static int unsigned hold_left = 0;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 3 * mjp_pkg::PIPE_LAT;
		end
		if (hold_left != 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else if (no_idle) begin
			m_axis_tready = 1'b1;
		end else begin
			if (run_left == 0) begin
				run_ready = ($urandom_range(0, 2) != 0);
				// Now and then a long stretch with no stall at all.
				run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 10);
				if (!run_ready && run_left > 10)
					run_left = 10;
			end
			m_axis_tready = run_ready;
			run_left--;
		end
	end

	// Offers one beat and returns once it has been taken. A random idle gap may
	// come first.
	task automatic send_joint(joint_in_t b, bit allow_gap = 1'b1);
		int unsigned n;
		if (allow_gap && !no_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_axis_tdata = {b.ty, b.tx, b.jy, b.jx, b.fy, b.fx};
		s_axis_tuser = b.inner;
		s_axis_tvalid = 1'b1;
		n = beats_in;
		do @(negedge clk); while (beats_in == n);
		s_axis_tvalid = 1'b0;
	endtask

	// Waits until every expected point has come back, then lets the pipeline
	// settle before the half-width may change.
	task automatic drain_results();
		while (join_q.size() != 0)
			@(negedge clk);
		repeat (mjp_pkg::PIPE_LAT + 4) @(negedge clk);
	endtask

	task automatic set_half_width(logic [mjp_pkg::HW_BITS-1:0] w);
		drain_results();
		cfg_wdata = w;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		hw_shadow = w;
	endtask

	function automatic joint_in_t make_joint(int fx, int fy, int jx, int jy, int tx,
			int ty, bit inner);
		joint_in_t b;
		b.fx = fx;
		b.fy = fy;
		b.jx = jx;
		b.jy = jy;
		b.tx = tx;
		b.ty = ty;
		b.inner = inner;
		return b;
	endfunction

	// Random coordinate around a center. Most spans are modest so that the
	// join lands inside the coordinate range, some are full 32-bit values.
	function automatic logic [31:0] rand_near(logic [31:0] c);
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return c + ($urandom & 32'h0000_ffff) - 32'h0000_8000;
			2: return c + ($urandom & 32'h00ff_ffff) - 32'h0080_0000;
			default: return c + ($urandom & 32'h0fff_ffff) - 32'h0800_0000;
		endcase
	endfunction

	// Random join: mostly well-formed corners, with zero-length legs,
	// collinear legs and full noise mixed in.
	function automatic joint_in_t rand_joint();
		joint_in_t   b;
		logic [31:0] dx, dy;
		int unsigned k;
		b.jx = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'h03ff_ffff) - 32'h0200_0000;
		b.jy = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'h03ff_ffff) - 32'h0200_0000;
		b.fx = rand_near(b.jx);
		b.fy = rand_near(b.jy);
		b.tx = rand_near(b.jx);
		b.ty = rand_near(b.jy);
		b.inner = 1'($urandom_range(0, 1));
		k = $urandom_range(0, 19);
		if (k == 0) begin
			b.fx = b.jx;
			b.fy = b.jy;
		end else if (k == 1) begin
			b.tx = b.jx;
			b.ty = b.jy;
		end else if (k == 2) begin
			// Legs along one line, same or opposite direction.
			dx = ($urandom & 32'h000f_ffff) + 1;
			dy = $urandom & 32'h000f_ffff;
			b.fx = b.jx - dx;
			b.fy = b.jy - dy;
			b.tx = $urandom_range(0, 1) ? b.jx + 2 * dx : b.jx - 3 * dx;
			b.ty = (b.tx == b.jx + 2 * dx) ? b.jy + 2 * dy : b.jy - 3 * dy;
		end else if (k == 3) begin
			// Nearly parallel: a small sideways step at a long distance.
			b.fx = b.jx - 32'h0100_0000;
			b.fy = b.jy;
			b.tx = b.jx + 32'h0100_0000;
			b.ty = b.jy + $urandom_range(0, 32'h0008_0000);
		end
		return b;
	endfunction

	// Extremes of the fields and every special case, at the reset half-width.
	task automatic test_directed();
		localparam int ONE = 65536;
		localparam int MAXC = 32'h7fff_ffff;
		localparam int MINC = 32'h8000_0000;
		send_joint(make_joint(-ONE, 0, 0, 0, 0, ONE, 0));
		send_joint(make_joint(-ONE, 0, 0, 0, 0, ONE, 1));
		send_joint(make_joint(0, 0, 0, 0, 0, ONE, 0));
		send_joint(make_joint(-ONE, 0, 0, 0, 0, 0, 1));
		send_joint(make_joint(5, 5, 5, 5, 5, 5, 0));
		send_joint(make_joint(-ONE, 0, 0, 0, ONE, 0, 0));
		send_joint(make_joint(-ONE, 0, 0, 0, -2 * ONE, 0, 1));
		send_joint(make_joint(MINC, MINC, MAXC, MAXC, MAXC, MINC, 0));
		send_joint(make_joint(MAXC, MAXC, MINC, MINC, MINC, MAXC, 1));
		send_joint(make_joint(MINC, 0, MAXC, 0, MAXC, 1, 0));
		send_joint(make_joint(0, MAXC, MAXC, MAXC, MAXC, 0, 1));
		send_joint(make_joint(MINC, MINC, MINC, MINC + 1, MINC + 2, MINC, 0));
		send_joint(make_joint(-32'h0100_0000, 0, 0, 0, 32'h0100_0000, 32'h0002_8f5c, 0));
		send_joint(make_joint(-32'h0100_0000, 0, 0, 0, 32'h0100_0000, 32'h0002_8f5d, 1));
		send_joint(make_joint(-32'h0100_0000, 0, 0, 0, 32'h0100_0000, 32'h0002_9000, 0));
		send_joint(make_joint(-1, 0, 0, 0, 0, 1, 1));
		send_joint(make_joint(-ONE, -ONE, 0, 0, ONE, -ONE, 0));
		send_joint(make_joint(ONE, 3, 0, 0, -ONE, 7, 1));
		send_joint(make_joint(-1, -1, -1, -1, -1, -1, 1));
		send_joint(make_joint(MAXC, 0, MAXC - 1, 0, MAXC - 1, 1, 0));
	endtask

	// Several half-widths, the extremes among them, each with a batch of joins.
	task automatic test_half_width_sweep();
		logic [mjp_pkg::HW_BITS-1:0] widths[6];
		widths = '{31'd0, 31'h7fff_ffff, 31'd1, 31'h0004_0000, 31'($urandom),
			mjp_pkg::HW_RESET};
		foreach (widths[i]) begin
			set_half_width(widths[i]);
			repeat (40) send_joint(rand_joint());
		end
	endtask

	// The receiver holds off for a long stretch while beats keep coming, so
	// the pipeline fills and the input must stall.
	task automatic test_backpressure();
		drain_results();
		hold_req++;
		repeat (mjp_pkg::PIPE_LAT + 60) send_joint(rand_joint(), 1'b0);
	endtask

	// The sender pauses until every result has come home, then goes on.
	task automatic test_sender_pause();
		repeat (30) send_joint(rand_joint());
		while (join_q.size() != 0)
			@(negedge clk);
		repeat (30) send_joint(rand_joint());
	endtask

	task automatic test_random(int unsigned n_items);
		repeat (n_items) send_joint(rand_joint());
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hw_shadow = mjp_pkg::HW_RESET;
		err_count = 0;
		beats_in = 0;
		hold_req = 0;
		no_idle = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_half_width_sweep();
		test_backpressure();
		test_sender_pause();
		set_half_width(31'($urandom_range(1, 32'h0010_0000)));
		test_random(700);
		// Last phase: no idling on either side.
		no_idle = 1'b1;
		test_random(200);

		while (join_q.size() != 0)
			@(negedge clk);
		repeat (mjp_pkg::PIPE_LAT + 10) @(negedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog, well beyond the slowest correct run.
	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
